>>> rtl/euler_angles_to_rotation_matrix_unit_macros.svh
// Assertion macros shared by the checker file.
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_UNIT_MACROS_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_UNIT_MACROS_SVH
// Assert that a property holds at every clock edge outside reset.
`define EAR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert that a property holds at every clock edge, reset included.
`define EAR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/ear_pkg.sv
// Package with the fixed-point types and the CORDIC constants.
`default_nettype none
package ear_pkg;
  localparam int unsigned AngleW = 20;
  localparam int unsigned OutW   = 16;
  localparam int unsigned IntW   = 34;
  localparam int unsigned MaxSteps = 32;

  typedef logic signed [AngleW-1:0] angle_t;
  typedef logic signed [OutW-1:0]   entry_t;
  typedef logic signed [IntW-1:0]   q30_t;

  typedef struct packed {
    angle_t pitch_angle;
    angle_t yaw_angle;
    angle_t roll_angle;
  } angles_t;

  typedef struct packed {
    entry_t m00; entry_t m01; entry_t m02;
    entry_t m10; entry_t m11; entry_t m12;
    entry_t m20; entry_t m21; entry_t m22;
  } matrix_t;

  localparam logic signed [33:0] KQ30       = 34'sd652032874;
  localparam logic signed [33:0] HalfPiQ30  = 34'sd1686629713;
  localparam logic signed [32:0] TwoOverPiQ32 = 33'sd2734261102;

  function automatic q30_t atan_q30(input logic [4:0] idx);
    q30_t r;
    r = '0;
    unique case (idx)
      5'd0:  r = 34'sd843314856;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043836;
      5'd3:  r = 34'sd133525158;
      5'd4:  r = 34'sd67021686;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775850;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194282;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      5'd24: r = 34'sd63;
      5'd25: r = 34'sd31;
      5'd26: r = 34'sd15;
      5'd27: r = 34'sd7;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q.30 product with round half up: floor((a*b + 2^29) / 2^30).
  function automatic q30_t mul30(input q30_t a, input q30_t b);
    logic signed [2*IntW-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    return p[IntW+29:30];
  endfunction
endpackage
`default_nettype wire

>>> rtl/ear_stream_if.sv
// Valid/ready channel that carries one payload item.
`default_nettype none
interface ear_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ear_sincos.sv
// Pipelined sine/cosine: quadrant reduction, unrolled CORDIC stages, quadrant fix.
`default_nettype none
module ear_sincos
  import ear_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = 16,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  wire logic   clk_i,
  input  wire logic   en_i,
  input  wire angle_t angle_i,
  output q30_t        sin_o,
  output q30_t        cos_o
);
  localparam int unsigned Steps = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;

  // Stage A: quadrant product
  logic signed [53:0] prod_q;
  angle_t             ang_q;
  // Stage B: remainder and quadrant
  q30_t       z0_q;
  logic [1:0] quad0_q;

  q30_t       x_q [Steps+1];
  q30_t       y_q [Steps+1];
  q30_t       z_q [Steps+1];
  logic [1:0] quad_q [Steps+1];

  logic signed [53:0] prod_d;
  logic signed [57:0] nsum;
  logic signed [IntW+1:0] n_full;
  logic signed [IntW+1:0] z0_d;

  assign prod_d = 54'(angle_i) * 54'(TwoOverPiQ32);
  always_comb begin
    nsum   = 58'(prod_q) + (58'sd1 <<< (31 + ANGLE_FRAC_BITS));
    n_full = (IntW+2)'(nsum >>> (32 + ANGLE_FRAC_BITS));
    z0_d   = ((IntW+2)'(ang_q) <<< (30 - ANGLE_FRAC_BITS)) - n_full * (IntW+2)'(HalfPiQ30);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      ang_q   <= angle_i;
      z0_q    <= z0_d[IntW-1:0];
      quad0_q <= n_full[1:0];
    end
  end

  assign x_q[0]    = KQ30;
  assign y_q[0]    = '0;
  assign z_q[0]    = z0_q;
  assign quad_q[0] = quad0_q;

  for (genvar i = 0; i < Steps; i++) begin : g_step
    q30_t dx;
    q30_t dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][IntW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_q30(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_q30(5'(i));
        end
        quad_q[i+1] <= quad_q[i];
      end
    end
  end

  always_comb begin
    unique case (quad_q[Steps])
      2'd0: begin cos_o = x_q[Steps];  sin_o = y_q[Steps];  end
      2'd1: begin cos_o = -y_q[Steps]; sin_o = x_q[Steps];  end
      2'd2: begin cos_o = -x_q[Steps]; sin_o = -y_q[Steps]; end
      default: begin cos_o = y_q[Steps]; sin_o = -x_q[Steps]; end
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/euler_angles_to_rotation_matrix_unit.sv
// Depth: CORDIC_STEPS + 6 register stages, with CORDIC_STEPS capped at MaxSteps.
// Throughput: one item per cycle; the whole pipeline advances when the output
// register is free or being taken, so a stall holds every stage.
// Reset clears only the stage valid bits; the datapath carries no reset.
// Matrix stages: sin/cos register, two product layers, rounding and clamp.
`default_nettype none
module euler_angles_to_rotation_matrix_unit
  import ear_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = 16,
  parameter int unsigned OUT_FRAC_BITS   = 14,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ear_stream_if.sink   in_if,
  ear_stream_if.source out_if
);
  localparam int unsigned Steps = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
  localparam int unsigned Depth = Steps + 6;

  logic en;
  logic [Depth-1:0] vld_q;
  assign en           = !vld_q[Depth-1] || out_if.ready;
  assign in_if.ready  = en;
  assign out_if.valid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_if.valid};
    end
  end

  angles_t ang;
  assign ang = in_if.data;
  q30_t sp, cp, sy, cy, sr, cr;

  ear_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_p (
    .clk_i, .en_i(en), .angle_i(ang.pitch_angle), .sin_o(sp), .cos_o(cp));
  ear_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_y (
    .clk_i, .en_i(en), .angle_i(ang.yaw_angle), .sin_o(sy), .cos_o(cy));
  ear_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_r (
    .clk_i, .en_i(en), .angle_i(ang.roll_angle), .sin_o(sr), .cos_o(cr));

  // Stage 1: register sines and cosines
  q30_t sp_q, cp_q, sy_q, cy_q, sr_q, cr_q;
  // Stage 2: first products
  q30_t srsp_q, crsp_q, cpcy_q, cpsy_q, srcp_q, crcp_q, crsy_q, crcy_q, srsy_q, srcy_q;
  q30_t sp2_q, sy2_q, cy2_q;
  // Stage 3: second products
  q30_t a00_q, a01_q, a02_q, a10_q, a11_q, a12_q, a20_q, a21_q, a22_q;
  q30_t b10_q, b11_q, b20_q, b21_q;
  matrix_t res_q;

  function automatic entry_t to_out(input q30_t e);
    q30_t v;
    q30_t lim;
    lim = q30_t'(1) <<< OUT_FRAC_BITS;
    if (OUT_FRAC_BITS >= 30) v = e;
    else v = (e + (q30_t'(1) <<< (29 - OUT_FRAC_BITS))) >>> (30 - OUT_FRAC_BITS);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[OutW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_q <= sp; cp_q <= cp; sy_q <= sy; cy_q <= cy; sr_q <= sr; cr_q <= cr;

      srsp_q <= mul30(sr_q, sp_q); crsp_q <= mul30(cr_q, sp_q);
      cpcy_q <= mul30(cp_q, cy_q); cpsy_q <= mul30(cp_q, sy_q);
      srcp_q <= mul30(sr_q, cp_q); crcp_q <= mul30(cr_q, cp_q);
      crsy_q <= mul30(cr_q, sy_q); crcy_q <= mul30(cr_q, cy_q);
      srsy_q <= mul30(sr_q, sy_q); srcy_q <= mul30(sr_q, cy_q);
      sp2_q <= sp_q; sy2_q <= sy_q; cy2_q <= cy_q;

      a00_q <= cpcy_q; a01_q <= cpsy_q; a02_q <= -sp2_q;
      a10_q <= mul30(srsp_q, cy2_q); b10_q <= crsy_q;
      a11_q <= mul30(srsp_q, sy2_q); b11_q <= crcy_q;
      a12_q <= srcp_q;
      a20_q <= mul30(crsp_q, cy2_q); b20_q <= srsy_q;
      a21_q <= mul30(crsp_q, sy2_q); b21_q <= srcy_q;
      a22_q <= crcp_q;

      res_q.m00 <= to_out(a00_q);
      res_q.m01 <= to_out(a01_q);
      res_q.m02 <= to_out(a02_q);
      res_q.m10 <= to_out(a10_q - b10_q);
      res_q.m11 <= to_out(a11_q + b11_q);
      res_q.m12 <= to_out(a12_q);
      res_q.m20 <= to_out(a20_q + b20_q);
      res_q.m21 <= to_out(a21_q - b21_q);
      res_q.m22 <= to_out(a22_q);
    end
  end

  assign out_if.data = res_q;
endmodule
`default_nettype wire

>>> rtl/ear_checker.sv
// Port-level checker for the rotation matrix unit, bound to the top level.
`default_nettype none
`include "euler_angles_to_rotation_matrix_unit_macros.svh"
module ear_checker
  import ear_pkg::*;
(
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    in_ready_i,
  input wire logic    out_valid_i,
  input wire logic    out_ready_i,
  input wire matrix_t out_data_i
);
  `EAR_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "stalled item changed")
  `EAR_ASSERT(a_ready_free, clk_i, rst_ni,
    !out_valid_i |-> in_ready_i, "input stalled with empty output")
  `EAR_ASSERT(a_ready_stall, clk_i, rst_ni,
    out_valid_i && !out_ready_i |-> !in_ready_i, "input taken during output stall")
  `EAR_ASSERT(a_m02_range, clk_i, rst_ni,
    out_valid_i |-> out_data_i.m02 <= 16'sd16384 && out_data_i.m02 >= -16'sd16384,
    "m02 outside range")
  `EAR_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_i, "valid after reset")
endmodule

bind euler_angles_to_rotation_matrix_unit ear_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data)
);
`default_nettype wire
